[rtl/xed_pkg.sv]
// Shared constants of the XML entity decoder: byte type and the entity table.
package xed_pkg;

  typedef logic [7:0] byte_t;

  localparam int ENT_N      = 6;
  localparam int ENT_MAXLEN = 6;

  localparam byte_t CHAR_AMP = 8'h26;

  // Entity spellings, unused tail bytes are zero.
  localparam byte_t ENT_TEXT [ENT_N][ENT_MAXLEN] = '{
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b},  // &nbsp;
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00}   // &amp;
  };

  localparam logic [3:0] ENT_LEN [ENT_N] = '{4'd6, 4'd6, 4'd4, 4'd4, 4'd6, 4'd5};

  localparam byte_t ENT_VALUE [ENT_N] = '{8'h22, 8'h27, 8'h3c, 8'h3e, 8'h20, 8'h26};

endpackage

[rtl/xed_front.sv]
// Front end: holds the entity prefix, classifies each byte and builds an emit record.
module xed_front import xed_pkg::*; #(
  parameter int MAX_ENTITY_LEN = 6,
  parameter int N_W            = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_byte,
  input  logic                                 end_of_stream,
  input  logic                                 push_ready,
  output logic                                 push,
  output logic [MAX_ENTITY_LEN-1:0][7:0]       rec_bytes,
  output logic [N_W-1:0]                       rec_count,
  output logic                                 rec_eos
);

  localparam int CNT_W  = $clog2(MAX_ENTITY_LEN);
  localparam int CAND_N = (MAX_ENTITY_LEN > ENT_MAXLEN) ? MAX_ENTITY_LEN : ENT_MAXLEN;

  byte_t            pending [MAX_ENTITY_LEN-1];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  byte_t            cand [CAND_N];
  logic             accept;
  logic             any_full;
  logic             any_pre;
  byte_t            value;
  logic             hold;
  logic             fresh_emit;
  logic             store_prefix;
  logic             restart;
  int               n_int;

  assign in_stall = !push_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    int  len;
    logic pm;
    for (int j = 0; j < CAND_N; j++) begin
      cand[j] = in_byte;
    end
    for (int j = 0; j < MAX_ENTITY_LEN - 1; j++) begin
      if (CNT_W'(j) < cnt) begin
        cand[j] = pending[j];
      end
    end
    len      = int'(cnt) + 1;
    any_full = 1'b0;
    any_pre  = 1'b0;
    value    = 8'h00;
    for (int e = ENT_N - 1; e >= 0; e--) begin
      pm = (int'(ENT_LEN[e]) <= MAX_ENTITY_LEN);
      for (int j = 0; j < ENT_MAXLEN; j++) begin
        if (j < len && cand[j] != ENT_TEXT[e][j]) begin
          pm = 1'b0;
        end
      end
      if (pm && int'(ENT_LEN[e]) == len) begin
        any_full = 1'b1;
        value    = ENT_VALUE[e];
      end
      if (pm && int'(ENT_LEN[e]) > len) begin
        any_pre = 1'b1;
      end
    end
  end

  always_comb begin
    hold         = (cnt != '0) && !any_full && any_pre
                   && (int'(cnt) + 1 <= MAX_ENTITY_LEN - 1);
    fresh_emit   = !(in_byte == CHAR_AMP && !end_of_stream);
    store_prefix = hold && !end_of_stream;
    restart      = !any_full && !hold && !fresh_emit;
    if (cnt == '0) begin
      n_int = fresh_emit ? 1 : 0;
    end else if (any_full) begin
      n_int = 1;
    end else if (hold) begin
      n_int = end_of_stream ? int'(cnt) + 1 : 0;
    end else begin
      n_int = int'(cnt) + (fresh_emit ? 1 : 0);
    end
    if (cnt != '0 && any_full) begin
      cnt_next = '0;
    end else if (store_prefix) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (restart) begin
      cnt_next = CNT_W'(1);
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTITY_LEN; i++) begin
      rec_bytes[i] = cand[i];
    end
    if (cnt != '0 && any_full) begin
      rec_bytes[0] = value;
    end
    rec_count = N_W'(n_int);
    rec_eos   = end_of_stream;
    push      = accept && (n_int != 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_ENTITY_LEN - 1; i++) begin
        if (store_prefix && CNT_W'(i) == cnt) begin
          pending[i] <= in_byte;
        end
      end
      if (restart) begin
        pending[0] <= in_byte;
      end
    end
  end

endmodule

[rtl/xed_queue.sv]
// Two-entry queue of emit records between the front and back ends.
module xed_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign push_ready = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/xed_back.sv]
// Back end: steps through the head record and hands out one byte per request.
module xed_back #(
  parameter int MAX_ENTITY_LEN = 6,
  parameter int N_W            = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  logic [MAX_ENTITY_LEN-1:0][7:0] head_bytes,
  input  logic [N_W-1:0]                 head_count,
  input  logic                           head_eos,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           run_last,
  output logic                           stream_done
);

  localparam int IDX_W = $clog2(MAX_ENTITY_LEN);

  logic [IDX_W-1:0] idx;
  logic             last;
  logic             accept;

  assign out_valid   = head_valid;
  assign out_byte    = head_bytes[idx];
  assign last        = (N_W'(idx) + N_W'(1)) == head_count;
  assign run_last    = last;
  assign stream_done = last && head_eos;
  assign accept      = out_valid && !out_stall;
  assign pop         = accept && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= last ? '0 : idx + IDX_W'(1);
    end
  end

endmodule

[rtl/xml_entity_decoder.sv]
// Top level of the streaming XML character-entity decoder.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  in_byte, end_of_stream
//   output    out        out_valid/out_stall  out_byte, run_last, stream_done
//
// Each input request is taken while in_stall is low; the front end classifies it at once.
// The output side moves one byte per cycle while out_stall is low, so a request
// that releases k held bytes occupies the back end until it has sent them all,
// during which the two-entry queue absorbs further input before in_stall rises.
// Reset (rst, synchronous) empties the queue and clears the held prefix.
// Held bytes themselves are payload and need no reset.
module xml_entity_decoder import xed_pkg::*; #(
  parameter int MAX_ENTITY_LEN = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_done
);

  // A record carries up to MAX_ENTITY_LEN bytes, its byte count and the
  // end-of-stream mark.
  localparam int N_W   = $clog2(MAX_ENTITY_LEN + 1);
  localparam int BYT_W = MAX_ENTITY_LEN * 8;
  localparam int REC_W = BYT_W + N_W + 1;

  logic                           push;
  logic                           push_ready;
  logic [MAX_ENTITY_LEN-1:0][7:0] rec_bytes;
  logic [N_W-1:0]                 rec_count;
  logic                           rec_eos;
  logic                           pop;
  logic                           head_valid;
  logic [REC_W-1:0]               head_data;

  // The front end owns the held entity prefix and decides, for each request,
  // which bytes go out: the held bytes, the current byte or a decoded character.
  xed_front #(
    .MAX_ENTITY_LEN (MAX_ENTITY_LEN),
    .N_W            (N_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .push_ready    (push_ready),
    .push          (push),
    .rec_bytes     (rec_bytes),
    .rec_count     (rec_count),
    .rec_eos       (rec_eos)
  );

  // Requests that only extend a held prefix produce no record and never
  // reach the queue.
  xed_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({rec_eos, rec_count, rec_bytes}),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // The back end serialises the head record; the last byte of a record
  // carries run_last, and stream_done as well when the record closed the stream.
  xed_back #(
    .MAX_ENTITY_LEN (MAX_ENTITY_LEN),
    .N_W            (N_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_bytes  (head_data[BYT_W-1:0]),
    .head_count  (head_data[BYT_W +: N_W]),
    .head_eos    (head_data[REC_W-1]),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_done (stream_done)
  );

endmodule
